// ===== rtl/core/ray_slab_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// ray slab intersect assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef RAY_SLAB_INTERSECT_ASSERT_SVH
`define RAY_SLAB_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray slab assertion failed");
`define RSI_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("ray slab latency assertion failed");
`else
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RSI_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons)
`endif
`endif

// ===== rtl/core/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// shared types, widths and helpers of the ray slab intersect block
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int W  = 32;
    localparam int F  = 16;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int EW = 2 * W + 3;
    localparam int RW = 3 * W;
    localparam int QW = W - 1;
    localparam int NC = W - 1;
    localparam int CIW = 3;

    typedef logic [CIW-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_COEF_A     = 3'd0;
    localparam t_cfg_idx REG_COEF_B     = 3'd1;
    localparam t_cfg_idx REG_COEF_C     = 3'd2;
    localparam t_cfg_idx REG_OFFSET_ONE = 3'd3;
    localparam t_cfg_idx REG_OFFSET_TWO = 3'd4;

    localparam logic CMD_INTERSECT = 1'b0;
    localparam logic CMD_NORMAL    = 1'b1;

    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_TWO  = 2'd2;

    localparam logic signed [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                cmd;
        logic signed [W-1:0] origin_x;
        logic signed [W-1:0] origin_y;
        logic signed [W-1:0] origin_z;
        logic signed [W-1:0] dir_x;
        logic signed [W-1:0] dir_y;
        logic signed [W-1:0] dir_z;
    } t_in;

    typedef struct packed {
        logic [1:0]          hit_count;
        logic signed [W-1:0] t_enter;
        logic signed [W-1:0] t_exit;
        logic                unbounded_span;
        logic signed [W-1:0] normal_x;
        logic signed [W-1:0] normal_y;
        logic signed [W-1:0] normal_z;
    } t_out;

    typedef struct packed {
        logic cmd;
        logic kzero;
        logic in_slab;
        logic neg1;
        logic neg2;
        logic ov1;
        logic ov2;
        logic pick_pos;
    } t_ctl;

    function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        r = (v == WORD_MIN) ? WORD_MAX : -v;
        return r;
    endfunction

    function automatic logic signed [W-1:0] quot_word(input logic [QW-1:0] q,
                                                      input logic ov, input logic neg);
        logic signed [W-1:0] m;
        logic signed [W-1:0] r;
        m = W'({1'b0, q});
        if (ov) begin
            r = neg ? WORD_MIN : WORD_MAX;
        end else begin
            r = neg ? -m : m;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front
// dot products, numerators and divider seed for the slab test
// ----------------------------------------------------------------------------
module rsi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  rsi_pkg::t_in                 i_item,
    input  logic signed [rsi_pkg::W-1:0] i_coef_a,
    input  logic signed [rsi_pkg::W-1:0] i_coef_b,
    input  logic signed [rsi_pkg::W-1:0] i_coef_c,
    input  logic signed [rsi_pkg::W-1:0] i_off_one,
    input  logic signed [rsi_pkg::W-1:0] i_off_two,
    output logic                         o_valid,
    output rsi_pkg::t_ctl                o_ctl,
    output logic [rsi_pkg::RW-1:0]       o_r1,
    output logic [rsi_pkg::RW-1:0]       o_r2,
    output logic [rsi_pkg::RW-1:0]       o_dd
);

    // products
    logic                          r_v1;
    logic                          r_cmd1;
    logic signed [rsi_pkg::PW-1:0] r_pox, r_poy, r_poz, r_pdx, r_pdy, r_pdz;

    // sums
    logic                          r_v2;
    logic                          r_cmd2;
    logic signed [rsi_pkg::SW-1:0] r_s, r_k;

    // numerators
    logic                          r_v3;
    logic                          r_cmd3, r_kzero3, r_inside3, r_neg13, r_neg23;
    logic [rsi_pkg::RW-1:0]        r_n1, r_n2, r_d;

    logic signed [rsi_pkg::EW-1:0] w_e1, w_e2, w_sum1, w_sum2;
    logic [rsi_pkg::EW-1:0]        w_abs1, w_abs2;
    logic [rsi_pkg::SW-1:0]        w_absk;
    logic                          w_pos1, w_pos2, w_kneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1 <= i_item.cmd;
        r_pox  <= rsi_pkg::PW'(i_coef_a) * rsi_pkg::PW'(i_item.origin_x);
        r_poy  <= rsi_pkg::PW'(i_coef_b) * rsi_pkg::PW'(i_item.origin_y);
        r_poz  <= rsi_pkg::PW'(i_coef_c) * rsi_pkg::PW'(i_item.origin_z);
        r_pdx  <= rsi_pkg::PW'(i_coef_a) * rsi_pkg::PW'(i_item.dir_x);
        r_pdy  <= rsi_pkg::PW'(i_coef_b) * rsi_pkg::PW'(i_item.dir_y);
        r_pdz  <= rsi_pkg::PW'(i_coef_c) * rsi_pkg::PW'(i_item.dir_z);
    end

    always_ff @(posedge i_clk) begin
        r_cmd2 <= r_cmd1;
        r_s <= rsi_pkg::SW'(r_pox) + rsi_pkg::SW'(r_poy) + rsi_pkg::SW'(r_poz);
        r_k <= rsi_pkg::SW'(r_pdx) + rsi_pkg::SW'(r_pdy) + rsi_pkg::SW'(r_pdz);
    end

    always_comb begin
        w_e1   = rsi_pkg::EW'(i_off_one) <<< rsi_pkg::F;
        w_e2   = rsi_pkg::EW'(i_off_two) <<< rsi_pkg::F;
        w_sum1 = rsi_pkg::EW'(r_s) + w_e1;
        w_sum2 = rsi_pkg::EW'(r_s) + w_e2;
        w_abs1 = w_sum1[rsi_pkg::EW-1] ? rsi_pkg::EW'(-w_sum1) : rsi_pkg::EW'(w_sum1);
        w_abs2 = w_sum2[rsi_pkg::EW-1] ? rsi_pkg::EW'(-w_sum2) : rsi_pkg::EW'(w_sum2);
        w_pos1 = !w_sum1[rsi_pkg::EW-1] && (w_sum1 != '0);
        w_pos2 = !w_sum2[rsi_pkg::EW-1] && (w_sum2 != '0);
        w_kneg = r_k[rsi_pkg::SW-1];
        w_absk = w_kneg ? rsi_pkg::SW'(-r_k) : rsi_pkg::SW'(r_k);
    end

    // numerator is -(s+e) shifted, so its sign is that of s+e inverted
    always_ff @(posedge i_clk) begin
        r_cmd3    <= r_cmd2;
        r_kzero3  <= (r_k == '0);
        r_inside3 <= w_pos1 && !w_pos2;
        r_neg13   <= w_pos1 ^ w_kneg;
        r_neg23   <= w_pos2 ^ w_kneg;
        r_n1      <= rsi_pkg::RW'(w_abs1) << rsi_pkg::F;
        r_n2      <= rsi_pkg::RW'(w_abs2) << rsi_pkg::F;
        r_d       <= rsi_pkg::RW'(w_absk);
    end

    always_ff @(posedge i_clk) begin
        o_ctl.cmd      <= r_cmd3;
        o_ctl.kzero    <= r_kzero3;
        o_ctl.in_slab  <= r_inside3;
        o_ctl.neg1     <= r_neg13;
        o_ctl.neg2     <= r_neg23;
        o_ctl.ov1      <= r_n1 >= (r_d << (rsi_pkg::W - 1));
        o_ctl.ov2      <= r_n2 >= (r_d << (rsi_pkg::W - 1));
        o_ctl.pick_pos <= r_n2 < r_n1;
        o_r1           <= r_n1;
        o_r2           <= r_n2;
        o_dd           <= r_d << (rsi_pkg::W - 2);
    end

endmodule

// ===== rtl/core/rsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// rsi_div_cell
// one restoring division step for both plane quotients
// ----------------------------------------------------------------------------
module rsi_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rsi_pkg::t_ctl          i_ctl,
    input  logic [rsi_pkg::RW-1:0] i_r1,
    input  logic [rsi_pkg::RW-1:0] i_r2,
    input  logic [rsi_pkg::RW-1:0] i_dd,
    input  logic [rsi_pkg::QW-1:0] i_q1,
    input  logic [rsi_pkg::QW-1:0] i_q2,
    output logic                   o_valid,
    output rsi_pkg::t_ctl          o_ctl,
    output logic [rsi_pkg::RW-1:0] o_r1,
    output logic [rsi_pkg::RW-1:0] o_r2,
    output logic [rsi_pkg::RW-1:0] o_dd,
    output logic [rsi_pkg::QW-1:0] o_q1,
    output logic [rsi_pkg::QW-1:0] o_q2
);

    logic w_ge1, w_ge2;

    assign w_ge1 = i_r1 >= i_dd;
    assign w_ge2 = i_r2 >= i_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_ctl <= i_ctl;
        o_r1  <= w_ge1 ? i_r1 - i_dd : i_r1;
        o_r2  <= w_ge2 ? i_r2 - i_dd : i_r2;
        o_dd  <= i_dd >> 1;
        o_q1  <= {i_q1[rsi_pkg::QW-2:0], w_ge1};
        o_q2  <= {i_q2[rsi_pkg::QW-2:0], w_ge2};
    end

endmodule

// ===== rtl/core/ray_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_slab_intersect
// ray against slab test and slab surface normal, Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage
//   config: write i_cfg_data to register i_cfg_idx while i_cfg_we is high
//   (coef a, b, c, offset one, offset two); write only while no word is in
//   flight
//   input: a word is taken at each edge with start high; busy stays low, so
//   one word per cycle is taken without gaps
//   output: o_res_valid marks o_res for one cycle after the word has passed
//   the pipeline; the receiver cannot stall, results leave in input order
//   pipeline: products, sums, numerators and overflow check, then a chain of
//   31 division cells with one quotient bit per cell, then an output register
//   throughput: one word per cycle, set by the fully pipelined cell chain
//   reset: clears the config registers and valid flags to zero and drops every word in flight
// ----------------------------------------------------------------------------
`include "ray_slab_intersect_assert.svh"

module ray_slab_intersect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rsi_pkg::t_in                i_item,
    input  logic                        i_cfg_we,
    input  rsi_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [rsi_pkg::W-1:0]       i_cfg_data,
    output logic                        o_res_valid,
    output rsi_pkg::t_out               o_res
);

    logic signed [rsi_pkg::W-1:0] r_coef_a, r_coef_b, r_coef_c, r_off_one, r_off_two;

    logic                   c_valid [rsi_pkg::NC+1];
    rsi_pkg::t_ctl          c_ctl   [rsi_pkg::NC+1];
    logic [rsi_pkg::RW-1:0] c_r1    [rsi_pkg::NC+1];
    logic [rsi_pkg::RW-1:0] c_r2    [rsi_pkg::NC+1];
    logic [rsi_pkg::RW-1:0] c_dd    [rsi_pkg::NC+1];
    logic [rsi_pkg::QW-1:0] c_q1    [rsi_pkg::NC+1];
    logic [rsi_pkg::QW-1:0] c_q2    [rsi_pkg::NC+1];

    rsi_pkg::t_ctl                w_ctl;
    logic signed [rsi_pkg::W-1:0] w_t1, w_t2;
    logic                         w_lt;
    rsi_pkg::t_out                n_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a  <= '0;
            r_coef_b  <= '0;
            r_coef_c  <= '0;
            r_off_one <= '0;
            r_off_two <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsi_pkg::REG_COEF_A:     r_coef_a  <= i_cfg_data;
                rsi_pkg::REG_COEF_B:     r_coef_b  <= i_cfg_data;
                rsi_pkg::REG_COEF_C:     r_coef_c  <= i_cfg_data;
                rsi_pkg::REG_OFFSET_ONE: r_off_one <= i_cfg_data;
                rsi_pkg::REG_OFFSET_TWO: r_off_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rsi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_item    (i_item),
        .i_coef_a  (r_coef_a),
        .i_coef_b  (r_coef_b),
        .i_coef_c  (r_coef_c),
        .i_off_one (r_off_one),
        .i_off_two (r_off_two),
        .o_valid   (c_valid[0]),
        .o_ctl     (c_ctl[0]),
        .o_r1      (c_r1[0]),
        .o_r2      (c_r2[0]),
        .o_dd      (c_dd[0])
    );

    assign c_q1[0] = '0;
    assign c_q2[0] = '0;

    for (genvar g = 0; g < rsi_pkg::NC; g++) begin : g_cell
        rsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_ctl   (c_ctl[g]),
            .i_r1    (c_r1[g]),
            .i_r2    (c_r2[g]),
            .i_dd    (c_dd[g]),
            .i_q1    (c_q1[g]),
            .i_q2    (c_q2[g]),
            .o_valid (c_valid[g+1]),
            .o_ctl   (c_ctl[g+1]),
            .o_r1    (c_r1[g+1]),
            .o_r2    (c_r2[g+1]),
            .o_dd    (c_dd[g+1]),
            .o_q1    (c_q1[g+1]),
            .o_q2    (c_q2[g+1])
        );
    end

    always_comb begin
        w_ctl = c_ctl[rsi_pkg::NC];
        w_t1  = rsi_pkg::quot_word(c_q1[rsi_pkg::NC], w_ctl.ov1, w_ctl.neg1);
        w_t2  = rsi_pkg::quot_word(c_q2[rsi_pkg::NC], w_ctl.ov2, w_ctl.neg2);
        w_lt  = w_t1 < w_t2;
        n_res = '0;
        if (w_ctl.cmd == rsi_pkg::CMD_NORMAL) begin
            if (w_ctl.pick_pos) begin
                n_res.normal_x = r_coef_a;
                n_res.normal_y = r_coef_b;
                n_res.normal_z = r_coef_c;
            end else begin
                n_res.normal_x = rsi_pkg::neg_sat(r_coef_a);
                n_res.normal_y = rsi_pkg::neg_sat(r_coef_b);
                n_res.normal_z = rsi_pkg::neg_sat(r_coef_c);
            end
        end else if (w_ctl.kzero) begin
            if (w_ctl.in_slab) begin
                n_res.hit_count      = rsi_pkg::HITS_TWO;
                n_res.t_enter        = rsi_pkg::WORD_MIN;
                n_res.t_exit         = rsi_pkg::WORD_MAX;
                n_res.unbounded_span = 1'b1;
            end
        end else begin
            n_res.hit_count = rsi_pkg::HITS_TWO;
            n_res.t_enter   = w_lt ? w_t1 : w_t2;
            n_res.t_exit    = w_lt ? w_t2 : w_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= c_valid[rsi_pkg::NC];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

    `RSI_ASSERT_IMPL(a_order, i_clk, i_rst_n,
        o_res_valid && o_res.hit_count == rsi_pkg::HITS_TWO, o_res.t_enter <= o_res.t_exit)
    `RSI_ASSERT_IMPL(a_span, i_clk, i_rst_n, o_res_valid && o_res.unbounded_span,
        o_res.hit_count == rsi_pkg::HITS_TWO && o_res.t_enter == rsi_pkg::WORD_MIN)
    `RSI_ASSERT_DELAY(a_latency, i_clk, i_rst_n, c_valid[0], rsi_pkg::NC + 1, o_res_valid)

endmodule

// ===== tb/ray_slab_intersect_test.sv =====
// ----------------------------------------------------------------------------
// ray_slab_intersect_test
// self-checking bench for the ray slab intersect block: a queue-fed driver,
// a clocked monitor and an exact wide-integer predictor of hits and normals,
// run over several plane settings and sender idling rates
// ----------------------------------------------------------------------------
module ray_slab_intersect_test;
    import rsi_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in               i_item = '0;
    logic              i_cfg_we = 1'b0;
    t_cfg_idx          i_cfg_idx = REG_COEF_A;
    logic [W-1:0]      i_cfg_data = '0;
    logic              o_res_valid;
    t_out              o_res;

    t_in               pending_rays[$];
    t_out              expected_results[$];
    logic [W-1:0]      plane_regs[5];
    int                idle_pct = 0;
    int                fail_count = 0;

    ray_slab_intersect DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_res_valid(o_res_valid), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [127:0] wide_of(input logic [W-1:0] v);
        return {{(128-W){v[W-1]}}, v};
    endfunction

    function automatic logic [W-1:0] negate_word(input logic [W-1:0] v);
        logic signed [127:0] n;
        n = -wide_of(v);
        if (n > wide_of(WORD_MAX)) n = wide_of(WORD_MAX);
        return n[W-1:0];
    endfunction

    function automatic logic [W-1:0] clamp_word(input logic signed [127:0] v);
        if (v > wide_of(WORD_MAX)) return WORD_MAX;
        if (v < wide_of(WORD_MIN)) return WORD_MIN;
        return v[W-1:0];
    endfunction

    function automatic t_out slab_result(input t_in r);
        t_out res;
        logic signed [127:0] s, k, e1, e2, t1, t2, d;
        res = '0;
        s = wide_of(plane_regs[REG_COEF_A]) * wide_of(r.origin_x)
          + wide_of(plane_regs[REG_COEF_B]) * wide_of(r.origin_y)
          + wide_of(plane_regs[REG_COEF_C]) * wide_of(r.origin_z);
        e1 = wide_of(plane_regs[REG_OFFSET_ONE]) <<< F;
        e2 = wide_of(plane_regs[REG_OFFSET_TWO]) <<< F;
        if (r.cmd == CMD_INTERSECT) begin
            k = wide_of(plane_regs[REG_COEF_A]) * wide_of(r.dir_x)
              + wide_of(plane_regs[REG_COEF_B]) * wide_of(r.dir_y)
              + wide_of(plane_regs[REG_COEF_C]) * wide_of(r.dir_z);
            if (k == 0) begin
                if (-e1 < s && s <= -e2) begin
                    res.hit_count = HITS_TWO;
                    res.t_enter = WORD_MIN;
                    res.t_exit = WORD_MAX;
                    res.unbounded_span = 1'b1;
                end
            end else begin
                t1 = wide_of(clamp_word((-(s + e1) <<< F) / k));
                t2 = wide_of(clamp_word((-(s + e2) <<< F) / k));
                res.hit_count = HITS_TWO;
                res.t_enter = (t1 < t2) ? t1[W-1:0] : t2[W-1:0];
                res.t_exit = (t1 < t2) ? t2[W-1:0] : t1[W-1:0];
            end
        end else begin
            d = -s;
            t1 = (d - e2 < 0) ? -(d - e2) : d - e2;
            t2 = (d - e1 < 0) ? -(d - e1) : d - e1;
            if (t1 < t2) begin
                res.normal_x = plane_regs[REG_COEF_A];
                res.normal_y = plane_regs[REG_COEF_B];
                res.normal_z = plane_regs[REG_COEF_C];
            end else begin
                res.normal_x = negate_word(plane_regs[REG_COEF_A]);
                res.normal_y = negate_word(plane_regs[REG_COEF_B]);
                res.normal_z = negate_word(plane_regs[REG_COEF_C]);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // plane register mirror
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (plane_regs[i]) plane_regs[i] <= '0;
        end else if (i_cfg_we && i_cfg_idx < 5) begin
            plane_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) expected_results.push_back(slab_result(i_item));
            if (pending_rays.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_item <= pending_rays.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (o_res.hit_count !== want.hit_count)
                    report_mismatch($sformatf("hit_count %0d want %0d",
                                              o_res.hit_count, want.hit_count));
                if (o_res.t_enter !== want.t_enter)
                    report_mismatch($sformatf("t_enter %h want %h",
                                              o_res.t_enter, want.t_enter));
                if (o_res.t_exit !== want.t_exit)
                    report_mismatch($sformatf("t_exit %h want %h", o_res.t_exit, want.t_exit));
                if (o_res.unbounded_span !== want.unbounded_span)
                    report_mismatch($sformatf("unbounded_span %b want %b",
                                              o_res.unbounded_span, want.unbounded_span));
                if (o_res.normal_x !== want.normal_x)
                    report_mismatch($sformatf("normal_x %h want %h",
                                              o_res.normal_x, want.normal_x));
                if (o_res.normal_y !== want.normal_y)
                    report_mismatch($sformatf("normal_y %h want %h",
                                              o_res.normal_y, want.normal_y));
                if (o_res.normal_z !== want.normal_z)
                    report_mismatch($sformatf("normal_z %h want %h",
                                              o_res.normal_z, want.normal_z));
            end
        end
    end

    task automatic write_plane(input t_cfg_idx idx, input logic [W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_slab(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] c, input logic [W-1:0] o1,
                            input logic [W-1:0] o2);
        write_plane(REG_COEF_A, a);
        write_plane(REG_COEF_B, b);
        write_plane(REG_COEF_C, c);
        write_plane(REG_OFFSET_ONE, o1);
        write_plane(REG_OFFSET_TWO, o2);
    endtask

    task automatic wait_drain;
        while (pending_rays.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] small_fix;
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    function automatic t_in make_ray(input logic c, input int ox, input int oy, input int oz,
                                     input int dx, input int dy, input int dz);
        t_in r;
        r.cmd = c;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        return r;
    endfunction

    function automatic t_in random_ray;
        t_in r;
        int mode;
        mode = $urandom_range(9);
        r = make_ray(1'($urandom_range(1)), small_fix(), small_fix(), small_fix(),
                     small_fix(), small_fix(), small_fix());
        case (mode)
            0, 1: begin
                r = make_ray(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            end
            2: begin
                r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
                r.cmd = CMD_INTERSECT;
            end
            3: begin
                r.dir_y = 0; r.dir_z = 0;
                r.dir_x = $urandom_range(1) ? 1 : -1;
            end
            4: begin
                r.origin_x = $urandom; r.dir_z = $urandom_range(1) ? WORD_MIN : WORD_MAX;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_phase(input int pct, input int count);
        idle_pct = pct;
        repeat (count) pending_rays.push_back(random_ray());
        wait_drain();
    endtask

    localparam int ONE = 32'h0001_0000;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slab -5 < x <= 5
        set_slab(ONE, 0, 0, 5 * ONE, -5 * ONE);
        idle_pct = 0;
        pending_rays.push_back(make_ray(CMD_INTERSECT, 0, 0, 0, ONE, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 0, 0, 0, -ONE, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 0, 0, 0, 1, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 0, ONE, ONE, 0, ONE, ONE));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 5 * ONE, 0, 0, 0, ONE, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, -5 * ONE, 0, 0, 0, 0, ONE));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 9 * ONE, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, WORD_MAX, WORD_MIN, WORD_MAX,
                                        WORD_MIN, WORD_MAX, WORD_MIN));
        pending_rays.push_back(make_ray(CMD_INTERSECT, WORD_MIN, 0, 0, WORD_MAX, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, -1, -1, -1, -1, -1, -1));
        pending_rays.push_back(make_ray(CMD_NORMAL, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_NORMAL, 4 * ONE, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_NORMAL, -4 * ONE, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_NORMAL, WORD_MAX, WORD_MAX, WORD_MAX, -1, -1, -1));
        pending_rays.push_back(make_ray(CMD_NORMAL, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0));
        wait_drain();

        set_slab(WORD_MIN, WORD_MAX, -1, WORD_MAX, WORD_MIN);
        pending_rays.push_back(make_ray(CMD_NORMAL, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_NORMAL, ONE, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, WORD_MAX, 0, 0, 1, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_INTERSECT, WORD_MIN, WORD_MIN, WORD_MIN,
                                        1, 1, 1));
        random_phase(0, 150);

        set_slab(small_fix(), small_fix(), small_fix(), 8 * ONE, -8 * ONE);
        random_phase(0, 140);
        // sender idles at random, holding back a ray with 61 percent chance each time
        random_phase(61, 140);

        set_slab($urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(11, 170);

        set_slab(0, 0, 0, small_fix(), small_fix());
        random_phase(61, 100);

        set_slab(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX);
        random_phase(0, 100);

        set_slab(ONE, -ONE, ONE / 2, 2 * ONE, -3 * ONE);
        random_phase(11, 150);

        set_slab(small_fix(), small_fix(), small_fix(), small_fix(), small_fix());
        random_phase(61, 130);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
